/* rtl/bgc_pkg.sv */
// Shared types and constants for the button gesture classifier.
package bgc_pkg;

  localparam logic [2:0]  PRESET_COUNT = 3'd6;
  localparam logic [2:0]  PRESET_FIRST = 3'd1;
  localparam logic [31:0] DEBOUNCE_MS  = 32'd30;
  localparam logic [7:0]  TAP_MAX      = 8'd255;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TAP_WINDOW     = 3'd0;
  localparam cfg_idx_t CFG_TAP_GOAL       = 3'd1;
  localparam cfg_idx_t CFG_LONG_HOLD      = 3'd2;
  localparam cfg_idx_t CFG_VERY_LONG_HOLD = 3'd3;
  localparam cfg_idx_t CFG_PRESET_TIMEOUT = 3'd4;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_NEXT      = 3'd1,
    EV_FREEZE    = 3'd2,
    EV_PRESET_ON = 3'd3,
    EV_SELECT    = 3'd4,
    EV_APPLY     = 3'd5,
    EV_TAP       = 3'd6,
    EV_TOGGLE    = 3'd7
  } ev_t;

  typedef struct packed {
    logic [15:0] tap_window_ms;
    logic [7:0]  tap_goal;
    logic [15:0] long_press_ms;
    logic [15:0] xlong_press_ms;
    logic [19:0] preset_timeout_ms;
  } cfg_t;

  typedef struct packed {
    ev_t        event_res;
    logic       timed_out;
    logic       frozen;
    logic       preset_on;
    logic [2:0] preset_index;
  } res_t;

endpackage

/* rtl/bgc_if.sv */
// Request channel interfaces: button ticks in, classified results out, register writes.
interface bgc_in_if;
  logic        valid;
  logic        ready;
  logic        button_level;
  logic [31:0] now_ms;
  modport source (output valid, button_level, now_ms, input ready);
  modport sink   (input valid, button_level, now_ms, output ready);
endinterface

interface bgc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       timed_out;
  logic       frozen;
  logic       preset_on;
  logic [2:0] preset_index;
  modport source (output valid, event_res, timed_out, frozen, preset_on, preset_index,
                  input ready);
  modport sink   (input valid, event_res, timed_out, frozen, preset_on, preset_index,
                  output ready);
endinterface

interface bgc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/bgc_cfg.sv */
// Configuration register file.
module bgc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]  wr_data,
  output bgc_pkg::cfg_t                   cfg
);
  import bgc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_window_ms     <= 16'd500;
      cfg_r.tap_goal          <= 8'd4;
      cfg_r.long_press_ms     <= 16'd1000;
      cfg_r.xlong_press_ms    <= 16'd3000;
      cfg_r.preset_timeout_ms <= 20'd10000;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TAP_WINDOW:     cfg_r.tap_window_ms     <= wr_data[15:0];
        CFG_TAP_GOAL:       cfg_r.tap_goal          <= wr_data[7:0];
        CFG_LONG_HOLD:      cfg_r.long_press_ms     <= wr_data[15:0];
        CFG_VERY_LONG_HOLD: cfg_r.xlong_press_ms    <= wr_data[15:0];
        CFG_PRESET_TIMEOUT: cfg_r.preset_timeout_ms <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/bgc_core.sv */
// Gesture state and single-pass classification of one tick.
module bgc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          level,
  input  logic [31:0]   now,
  input  bgc_pkg::cfg_t cfg,
  output bgc_pkg::res_t res
);
  import bgc_pkg::*;

  logic        prev_level_r, prev_level_nxt;
  logic [31:0] change_time_r, change_time_nxt;
  logic [31:0] press_time_r, press_time_nxt;
  logic [7:0]  tap_count_r, tap_count_nxt;
  logic [31:0] tap_time_r, tap_time_nxt;
  logic        freeze_r, freeze_nxt;
  logic        preset_r, preset_nxt;
  logic [2:0]  choice_r, choice_nxt;
  logic [31:0] activity_r, activity_nxt;

  logic [31:0] idle, since_change, held, tap_gap;
  logic [7:0]  cnt_base, cnt_inc;
  logic        tout, pm, accepted;
  ev_t         ev;

  always_comb begin
    idle         = now - activity_r;
    since_change = now - change_time_r;
    held         = now - press_time_r;
    tap_gap      = now - tap_time_r;
    cnt_base     = (tap_gap > {16'd0, cfg.tap_window_ms}) ? 8'd0 : tap_count_r;
    cnt_inc      = (cnt_base < TAP_MAX) ? cnt_base + 8'd1 : cnt_base;

    prev_level_nxt  = prev_level_r;
    change_time_nxt = change_time_r;
    press_time_nxt  = press_time_r;
    tap_count_nxt   = tap_count_r;
    tap_time_nxt    = tap_time_r;
    freeze_nxt      = freeze_r;
    choice_nxt      = choice_r;
    activity_nxt    = activity_r;
    ev              = EV_NONE;

    tout = preset_r && (idle > {12'd0, cfg.preset_timeout_ms});
    pm   = preset_r && !tout;
    preset_nxt = pm;

    accepted = (level != prev_level_r) && (since_change >= DEBOUNCE_MS);
    if (accepted) begin
      change_time_nxt = now;
      prev_level_nxt  = level;
      if (!level) begin
        press_time_nxt = now;
      end else if (pm) begin
        if (held >= {16'd0, cfg.long_press_ms}) begin
          preset_nxt = 1'b0;
          ev         = EV_APPLY;
        end else begin
          tap_count_nxt = 8'd0;
          tap_time_nxt  = 32'd0;
          choice_nxt    = (choice_r >= PRESET_COUNT) ? PRESET_FIRST : choice_r + 3'd1;
          activity_nxt  = now;
          ev            = EV_SELECT;
        end
      end else if (held >= {16'd0, cfg.xlong_press_ms} && freeze_r) begin
        preset_nxt   = 1'b1;
        choice_nxt   = PRESET_FIRST;
        activity_nxt = now;
        ev           = EV_PRESET_ON;
      end else if (held >= {16'd0, cfg.long_press_ms}) begin
        tap_count_nxt = 8'd0;
        tap_time_nxt  = 32'd0;
        freeze_nxt    = !freeze_r;
        ev            = EV_FREEZE;
      end else if (freeze_r) begin
        tap_time_nxt = now;
        if (cnt_inc >= cfg.tap_goal) begin
          tap_count_nxt = 8'd0;
          ev            = EV_TOGGLE;
        end else begin
          tap_count_nxt = cnt_inc;
          ev            = EV_TAP;
        end
      end else begin
        ev = EV_NEXT;
      end
    end

    res.event_res    = ev;
    res.timed_out    = tout;
    res.frozen       = freeze_nxt;
    res.preset_on    = preset_nxt;
    res.preset_index = choice_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b1;
      change_time_r <= 32'd0;
      press_time_r  <= 32'd0;
      tap_count_r   <= 8'd0;
      tap_time_r    <= 32'd0;
      freeze_r      <= 1'b0;
      preset_r      <= 1'b0;
      choice_r      <= PRESET_FIRST;
      activity_r    <= 32'd0;
    end else if (step) begin
      prev_level_r  <= prev_level_nxt;
      change_time_r <= change_time_nxt;
      press_time_r  <= press_time_nxt;
      tap_count_r   <= tap_count_nxt;
      tap_time_r    <= tap_time_nxt;
      freeze_r      <= freeze_nxt;
      preset_r      <= preset_nxt;
      choice_r      <= choice_nxt;
      activity_r    <= activity_nxt;
    end
  end

endmodule

/* rtl/button_gesture_classifier.sv */
// Button gesture classifier top level: input register, classifier, result register.
//
// in_ch carries one tick per request: button_level (0 pressed) and now_ms.
// out_ch returns exactly one result per tick: event_res, timed_out, frozen,
// preset_on and preset_index, all reflecting state after that tick.
// cfg_ch writes the five registers by index; it is always ready and should
// only be used while no ticks are in flight.
// A tick accepted on in_ch is held in the input register, classified, and
// registered in the result register, from which out_ch shows it. Throughput
// is one tick per cycle while out_ch is not stalled; the classifier's state
// registers feed straight back into the classification of the next tick.
// When out_ch stalls the result register holds and the input register fills;
// in_ch.ready then drops until the result is taken.
// Synchronous active-low reset returns the configuration to its defaults,
// the gesture state to released / not frozen / no preset, and empties both
// registers.
module button_gesture_classifier (
  input  logic clk,
  input  logic rst_n,
  bgc_in_if.sink    in_ch,
  bgc_out_if.source out_ch,
  bgc_cfg_if.sink   cfg_ch
);
  import bgc_pkg::*;

  logic        in_valid_r;
  logic        in_level_r;
  logic [31:0] in_now_r;
  logic        out_valid_r;
  res_t        res_r;
  res_t        res_nxt;
  cfg_t        cfg;
  logic        step;

  assign step        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step;
  assign cfg_ch.ready = 1'b1;

  bgc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  bgc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (in_level_r),
    .now   (in_now_r),
    .cfg   (cfg),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_level_r <= in_ch.button_level;
      in_now_r   <= in_ch.now_ms;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_res    = res_r.event_res;
  assign out_ch.timed_out    = res_r.timed_out;
  assign out_ch.frozen       = res_r.frozen;
  assign out_ch.preset_on    = res_r.preset_on;
  assign out_ch.preset_index = res_r.preset_index;

endmodule

/* rtl/bgc_checker.sv */
// Port-level assertions for the button gesture classifier, bound to the top level.
module bgc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic       timed_out,
  input logic       frozen,
  input logic       preset_on,
  input logic [2:0] preset_index
);
  import bgc_pkg::*;

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (preset_index >= PRESET_FIRST) && (preset_index <= PRESET_COUNT))
    else $error("preset selection out of range");

  a_preset_enter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_PRESET_ON) |->
      preset_on && frozen && (preset_index == PRESET_FIRST))
    else $error("preset entry without frozen preset state");

  a_leave_preset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_APPLY ||
                  (timed_out && event_res != EV_PRESET_ON)) |-> !preset_on)
    else $error("preset mode still on after apply or timeout");

  a_tap_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_TAP || event_res == EV_TOGGLE) |-> frozen && !preset_on)
    else $error("tap event outside frozen normal mode");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(preset_index))
    else $error("result changed while stalled");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_res    (out_ch.event_res),
  .timed_out    (out_ch.timed_out),
  .frozen       (out_ch.frozen),
  .preset_on    (out_ch.preset_on),
  .preset_index (out_ch.preset_index)
);
